// ===== src/gest_pkg.sv =====
// Shared types, constants and helper functions of the gas exposure STEL/TWA unit.
package gest_pkg;

    localparam int CONC_W        = 16;
    localparam int LEVEL_W       = 16;
    localparam int TWA_ACC_W     = 20;
    localparam int TWA_SCALE     = 10;
    localparam int TWA_MINUTES   = 15;
    localparam int STEL_EVERY    = 5;
    localparam int PHASE_W       = 3;
    localparam int MINUTE_CNT_W  = 4;

    localparam int DEF_SAMPLES_PER_PERIOD = 60;
    localparam int DEF_WINDOW_PERIODS     = 15;
    localparam int DEF_TWA_WEIGHT         = 32;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AVG,
        ST_PREP,
        ST_OLD,
        ST_PART,
        ST_STEL,
        ST_TWA_PREP,
        ST_TWA,
        ST_TWA_LVL,
        ST_EMIT
    } seq_state_t;

    typedef enum logic [1:0] {
        DIV_RECIP,
        DIV_BACK,
        DIV_FIX
    } div_step_t;

    function automatic int gest_max(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    // Clamp a quotient to the 16-bit level range.
    function automatic logic [LEVEL_W-1:0] sat16(input logic [31:0] v);
        return (v > 32'h0000_FFFF) ? {LEVEL_W{1'b1}} : v[LEVEL_W-1:0];
    endfunction

endpackage

// ===== src/gest_if.sv =====
// Valid/ready stream interfaces for the sample and result channels.
interface gest_sample_if import gest_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CONC_W-1:0] concentration;

    modport source (output valid, output concentration, input ready);
    modport sink   (input valid, input concentration, output ready);
endinterface

interface gest_result_if import gest_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] stel_level;
    logic               stel_fresh;
    logic [LEVEL_W-1:0] twa_level;
    logic               twa_fresh;

    modport source (output valid, output stel_level, output stel_fresh,
                    output twa_level, output twa_fresh, input ready);
    modport sink   (input valid, input stel_level, input stel_fresh,
                    input twa_level, input twa_fresh, output ready);
endinterface

// ===== src/gest_div.sv =====
// Shared constant divider: reciprocal multiply, back-multiply and one correction step.
module gest_div import gest_pkg::*; #(
    parameter int DVD_W = 32,
    parameter int DVS_W = 9
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    input  logic [DVD_W-1:0] recip,
    output logic             busy,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int PROD_W = 2 * DVD_W;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    div_step_t         step_reg, step_next;
    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [DVS_W-1:0]  dvs_reg, dvs_next;
    logic [DVD_W-1:0]  rcp_reg, rcp_next;
    logic [DVD_W-1:0]  quo_reg, quo_next;
    logic [DVD_W-1:0]  rem_reg, rem_next;
    logic [DVD_W-1:0]  mul_a;
    logic [DVD_W-1:0]  mul_b;
    logic [PROD_W-1:0] product;

    // The reciprocal is rounded down, so the first estimate is exact or one short.
    assign mul_a   = (step_reg == DIV_BACK) ? quo_reg : dvd_reg;
    assign mul_b   = (step_reg == DIV_BACK) ? DVD_W'(dvs_reg) : rcp_reg;
    assign product = PROD_W'(mul_a) * PROD_W'(mul_b);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rcp_next  = rcp_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = DIV_RECIP;
            dvd_next  = dividend;
            dvs_next  = divisor;
            rcp_next  = recip;
        end
        else if (busy_reg)
        begin
            unique case (step_reg)
                DIV_RECIP:
                begin
                    quo_next  = product[PROD_W-1:DVD_W];
                    step_next = DIV_BACK;
                end

                DIV_BACK:
                begin
                    rem_next  = dvd_reg - product[DVD_W-1:0];
                    step_next = DIV_FIX;
                end

                DIV_FIX:
                begin
                    if (rem_reg >= DVD_W'(dvs_reg))
                    begin
                        quo_next = quo_reg + 1'b1;
                    end
                    busy_next = 1'b0;
                    done_next = 1'b1;
                    step_next = DIV_RECIP;
                end

                default:
                begin
                    busy_next = 1'b0;
                    step_next = DIV_RECIP;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= DIV_RECIP;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rcp_reg <= rcp_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== src/gest_window.sv =====
// Window of period averages as a shift line with a running total.
module gest_window import gest_pkg::*; #(
    parameter int DEPTH = DEF_WINDOW_PERIODS,
    parameter int SUM_W = CONC_W + $clog2(DEF_WINDOW_PERIODS)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               shift_en,
    input  logic [CONC_W-1:0]  shift_data,
    output logic [CONC_W-1:0]  oldest,
    output logic [SUM_W-1:0]   total
);

    logic [CONC_W-1:0] taps_reg [DEPTH];
    logic [SUM_W-1:0]  total_reg, total_next;

    // The total tracks every entry, so the oldest leaves as the newest enters.
    assign total_next = total_reg - SUM_W'(taps_reg[0]) + SUM_W'(shift_data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                taps_reg[i] <= '0;
            end
            total_reg <= '0;
        end
        else if (shift_en)
        begin
            for (int i = 0; i < DEPTH - 1; i++)
            begin
                taps_reg[i] <= taps_reg[i+1];
            end
            taps_reg[DEPTH-1] <= shift_data;
            total_reg         <= total_next;
        end
    end

    assign oldest = taps_reg[0];
    assign total  = total_reg;

endmodule

// ===== src/gas_exposure_stel_twa_unit.sv =====
// Top level of the gas exposure unit: sequencer around the shared divider and window.
//
//   Channel   Direction  Payload                                        Transfer
//   samples   in         concentration                                  valid && ready
//   results   out        stel_level, stel_fresh, twa_level, twa_fresh   valid && ready
//
// A sample that does not fall on a STEL point goes straight to the emit step. A STEL point
// takes three divisions (oldest share, partial period, window average); the end of a period
// adds the period average division first, and a TWA update a setup step and two more divisions.
// All divisions use the shared reciprocal divider; samples is ready only when idle.
// Reset clears the window, the period sum, the TWA accumulator and the held STEL and TWA levels to zero.
// A result waits in the output register; a stalled results channel holds the next sample
// in its final step until the transfer completes.
module gas_exposure_stel_twa_unit import gest_pkg::*; #(
    parameter int SAMPLES_PER_PERIOD = DEF_SAMPLES_PER_PERIOD,
    parameter int WINDOW_PERIODS     = DEF_WINDOW_PERIODS,
    parameter int TWA_WEIGHT         = DEF_TWA_WEIGHT
) (
    input  logic             clk,
    input  logic             rst_n,
    gest_sample_if.sink      samples,
    gest_result_if.source    results
);

    localparam int IDX_W  = $clog2(SAMPLES_PER_PERIOD);
    localparam int SUM_W  = CONC_W + $clog2(SAMPLES_PER_PERIOD);
    localparam int WIN_W  = CONC_W + $clog2(WINDOW_PERIODS);
    localparam int ACC_W  = CONC_W + $clog2(WINDOW_PERIODS + 2);
    localparam int MUL_W  = CONC_W + IDX_W + 1;
    localparam int T_W    = TWA_ACC_W + $clog2(TWA_WEIGHT) + 1;
    localparam int DVD_W  = gest_max(gest_max(SUM_W + 1, MUL_W),
                                     gest_max(gest_max(ACC_W, T_W), TWA_ACC_W));
    localparam int DVS_W  = gest_max(gest_max($clog2(SAMPLES_PER_PERIOD + 1),
                                              $clog2(WINDOW_PERIODS + 1)),
                                     gest_max($clog2(TWA_WEIGHT + 1),
                                              $clog2(TWA_SCALE + 1)));
    localparam int HALF_S = SAMPLES_PER_PERIOD / 2;
    localparam int HALF_W = WINDOW_PERIODS / 2;

    // Reciprocals of the fixed divisors, scaled by 2^DVD_W and rounded down.
    localparam longint unsigned RCP_PER = (64'd1 << DVD_W) / SAMPLES_PER_PERIOD;
    localparam longint unsigned RCP_WIN = (64'd1 << DVD_W) / WINDOW_PERIODS;
    localparam longint unsigned RCP_WT  = (64'd1 << DVD_W) / TWA_WEIGHT;
    localparam longint unsigned RCP_SCL = (64'd1 << DVD_W) / TWA_SCALE;

    seq_state_t               state_reg, state_next;
    logic [SUM_W-1:0]         minute_sum_reg, minute_sum_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [PHASE_W-1:0]       phase_reg, phase_next;
    logic [MINUTE_CNT_W-1:0]  minutes_reg, minutes_next;
    logic [ACC_W-1:0]         acc_reg, acc_next;
    logic [LEVEL_W-1:0]       stel_hold_reg, stel_hold_next;
    logic [TWA_ACC_W-1:0]     twa_accum_reg, twa_accum_next;
    logic [LEVEL_W-1:0]       twa_hold_reg, twa_hold_next;
    logic                     stel_fresh_reg, stel_fresh_next;
    logic                     twa_fresh_reg, twa_fresh_next;
    logic                     out_valid_reg, out_valid_next;
    logic [LEVEL_W-1:0]       out_stel_reg, out_stel_next;
    logic                     out_stel_fresh_reg, out_stel_fresh_next;
    logic [LEVEL_W-1:0]       out_twa_reg, out_twa_next;
    logic                     out_twa_fresh_reg, out_twa_fresh_next;

    logic                     div_start;
    logic [DVD_W-1:0]         div_dividend;
    logic [DVS_W-1:0]         div_divisor;
    logic [DVD_W-1:0]         div_recip;
    logic                     div_busy;
    logic                     div_done;
    logic [DVD_W-1:0]         div_quotient;

    logic                     shift_en;
    logic [CONC_W-1:0]        shift_data;
    logic [CONC_W-1:0]        oldest;
    logic [WIN_W-1:0]         win_total;

    logic [SUM_W-1:0]         sum_inc;
    logic [IDX_W:0]           idx_inc;
    logic [IDX_W:0]           remaining;
    logic [MUL_W-1:0]         old_prod;
    logic [T_W-1:0]           twa_t;
    logic                     sample_xfer;

    gest_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .recip    (div_recip),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    gest_window #(
        .DEPTH (WINDOW_PERIODS),
        .SUM_W (WIN_W)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .shift_en   (shift_en),
        .shift_data (shift_data),
        .oldest     (oldest),
        .total      (win_total)
    );

    assign samples.ready = (state_reg == ST_IDLE);
    assign sample_xfer   = samples.valid && samples.ready;

    assign sum_inc   = minute_sum_reg + SUM_W'(samples.concentration);
    assign idx_inc   = {1'b0, idx_reg} + 1'b1;
    assign remaining = (IDX_W+1)'(SAMPLES_PER_PERIOD) - {1'b0, idx_reg};
    assign old_prod  = MUL_W'(oldest) * MUL_W'(remaining);
    assign twa_t     = T_W'(twa_accum_reg) * T_W'(TWA_WEIGHT - 1)
                     + T_W'(stel_hold_reg) * T_W'(TWA_SCALE);

    always_comb
    begin
        state_next          = state_reg;
        minute_sum_next     = minute_sum_reg;
        idx_next            = idx_reg;
        phase_next          = phase_reg;
        minutes_next        = minutes_reg;
        acc_next            = acc_reg;
        stel_hold_next      = stel_hold_reg;
        twa_accum_next      = twa_accum_reg;
        twa_hold_next       = twa_hold_reg;
        stel_fresh_next     = stel_fresh_reg;
        twa_fresh_next      = twa_fresh_reg;
        out_valid_next      = out_valid_reg;
        out_stel_next       = out_stel_reg;
        out_stel_fresh_next = out_stel_fresh_reg;
        out_twa_next        = out_twa_reg;
        out_twa_fresh_next  = out_twa_fresh_reg;
        div_start           = 1'b0;
        div_dividend        = '0;
        div_divisor         = '0;
        div_recip           = '0;
        shift_en            = 1'b0;
        shift_data          = '0;

        if (out_valid_reg && results.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (samples.valid)
                begin
                    stel_fresh_next = 1'b0;
                    twa_fresh_next  = 1'b0;
                    if (idx_inc == (IDX_W+1)'(SAMPLES_PER_PERIOD))
                    begin
                        // Period complete: rounded average of the full sum.
                        div_start       = 1'b1;
                        div_dividend    = DVD_W'(sum_inc) + DVD_W'(HALF_S);
                        div_divisor     = DVS_W'(SAMPLES_PER_PERIOD);
                        div_recip       = DVD_W'(RCP_PER);
                        minute_sum_next = '0;
                        idx_next        = '0;
                        phase_next      = '0;
                        minutes_next    = minutes_reg + 1'b1;
                        state_next      = ST_AVG;
                    end
                    else
                    begin
                        minute_sum_next = sum_inc;
                        idx_next        = idx_inc[IDX_W-1:0];
                        if (phase_reg == PHASE_W'(STEL_EVERY - 1))
                        begin
                            phase_next = '0;
                            state_next = ST_PREP;
                        end
                        else
                        begin
                            phase_next = phase_reg + 1'b1;
                            state_next = ST_EMIT;
                        end
                    end
                end
            end

            ST_AVG:
            begin
                if (div_done)
                begin
                    shift_en   = 1'b1;
                    shift_data = sat16(32'(div_quotient));
                    state_next = ST_PREP;
                end
            end

            ST_PREP:
            begin
                // Share of the oldest period that still lies inside the window.
                div_start    = 1'b1;
                div_dividend = DVD_W'(old_prod);
                div_divisor  = DVS_W'(SAMPLES_PER_PERIOD);
                div_recip    = DVD_W'(RCP_PER);
                state_next   = ST_OLD;
            end

            ST_OLD:
            begin
                if (div_done)
                begin
                    acc_next     = ACC_W'(win_total) - ACC_W'(oldest)
                                 + ACC_W'(div_quotient);
                    div_start    = 1'b1;
                    div_dividend = DVD_W'(minute_sum_reg);
                    div_divisor  = DVS_W'(SAMPLES_PER_PERIOD);
                    div_recip    = DVD_W'(RCP_PER);
                    state_next   = ST_PART;
                end
            end

            ST_PART:
            begin
                if (div_done)
                begin
                    div_start    = 1'b1;
                    div_dividend = DVD_W'(acc_reg) + div_quotient + DVD_W'(HALF_W);
                    div_divisor  = DVS_W'(WINDOW_PERIODS);
                    div_recip    = DVD_W'(RCP_WIN);
                    state_next   = ST_STEL;
                end
            end

            ST_STEL:
            begin
                if (div_done)
                begin
                    stel_hold_next  = sat16(32'(div_quotient));
                    stel_fresh_next = 1'b1;
                    if (minutes_reg == MINUTE_CNT_W'(TWA_MINUTES))
                    begin
                        state_next = ST_TWA_PREP;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end

            ST_TWA_PREP:
            begin
                div_start    = 1'b1;
                div_dividend = DVD_W'(twa_t);
                div_divisor  = DVS_W'(TWA_WEIGHT);
                div_recip    = DVD_W'(RCP_WT);
                state_next   = ST_TWA;
            end

            ST_TWA:
            begin
                if (div_done)
                begin
                    twa_accum_next = div_quotient[TWA_ACC_W-1:0];
                    div_start      = 1'b1;
                    div_dividend   = DVD_W'(div_quotient[TWA_ACC_W-1:0]);
                    div_divisor    = DVS_W'(TWA_SCALE);
                    div_recip      = DVD_W'(RCP_SCL);
                    state_next     = ST_TWA_LVL;
                end
            end

            ST_TWA_LVL:
            begin
                if (div_done)
                begin
                    twa_hold_next  = sat16(32'(div_quotient));
                    twa_fresh_next = 1'b1;
                    minutes_next   = '0;
                    state_next     = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_valid_next      = 1'b1;
                    out_stel_next       = stel_hold_reg;
                    out_stel_fresh_next = stel_fresh_reg;
                    out_twa_next        = twa_hold_reg;
                    out_twa_fresh_next  = twa_fresh_reg;
                    state_next          = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            minute_sum_reg <= '0;
            idx_reg        <= '0;
            phase_reg      <= '0;
            minutes_reg    <= '0;
            stel_hold_reg  <= '0;
            twa_accum_reg  <= '0;
            twa_hold_reg   <= '0;
            stel_fresh_reg <= 1'b0;
            twa_fresh_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            minute_sum_reg <= minute_sum_next;
            idx_reg        <= idx_next;
            phase_reg      <= phase_next;
            minutes_reg    <= minutes_next;
            stel_hold_reg  <= stel_hold_next;
            twa_accum_reg  <= twa_accum_next;
            twa_hold_reg   <= twa_hold_next;
            stel_fresh_reg <= stel_fresh_next;
            twa_fresh_reg  <= twa_fresh_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg            <= acc_next;
        out_stel_reg       <= out_stel_next;
        out_stel_fresh_reg <= out_stel_fresh_next;
        out_twa_reg        <= out_twa_next;
        out_twa_fresh_reg  <= out_twa_fresh_next;
    end

    assign results.valid      = out_valid_reg;
    assign results.stel_level = out_stel_reg;
    assign results.stel_fresh = out_stel_fresh_reg;
    assign results.twa_level  = out_twa_reg;
    assign results.twa_fresh  = out_twa_fresh_reg;

    // A TWA update only happens at a period boundary, which is always a STEL point.
    a_twa_implies_stel: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.twa_fresh |-> results.stel_fresh)
        else $error("TWA update without STEL update");

    a_phase_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg == '0 |-> phase_reg == '0)
        else $error("STEL phase out of step with sample index");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, idx_reg} < (IDX_W+1)'(SAMPLES_PER_PERIOD))
        else $error("sample index beyond period length");

    a_div_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_sample_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        sample_xfer |=> state_reg != ST_IDLE)
        else $error("accepted sample left no work");

endmodule

// ===== tb/tb_gas_exposure_stel_twa_unit.sv =====
// Self-checking testbench for the gas exposure STEL/TWA unit.
module tb_gas_exposure_stel_twa_unit;
    import gest_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 11;
    localparam int PERIOD_SAMPLES = DEF_SAMPLES_PER_PERIOD;
    localparam int WINDOW_LEN     = DEF_WINDOW_PERIODS;
    localparam int TWA_WT         = DEF_TWA_WEIGHT;
    localparam int SETTLE_CYCLES  = 400;
    localparam int LIMIT_CYCLES   = 1_000_000;
    localparam longint unsigned ACC_MASK = (64'd1 << TWA_ACC_W) - 1;

    typedef struct packed {
        logic [LEVEL_W-1:0] stel_level;
        logic               stel_fresh;
        logic [LEVEL_W-1:0] twa_level;
        logic               twa_fresh;
    } exposure_t;

    typedef enum int {
        PROF_FULL,
        PROF_LOW,
        PROF_HIGH,
        PROF_FLAT
    } conc_profile_t;

    logic clk;
    logic rst_n;

    gest_sample_if sample_ch ();
    gest_result_if result_ch ();

    gas_exposure_stel_twa_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_ch),
        .results (result_ch)
    );

    // Shadow of the unit's exposure state.
    longint unsigned  sh_minute_sum;
    int               sh_sample_idx;
    logic [15:0]      sh_window [WINDOW_LEN];
    int               sh_minutes;
    logic [15:0]      sh_stel;
    longint unsigned  sh_twa_acc;
    logic [15:0]      sh_twa;

    exposure_t pending_levels[$];

    int mismatch_count;
    int samples_sent;
    int results_seen;
    int stel_refreshes;
    int twa_updates;

    bit tx_idle_on;
    bit rx_idle_on;
    int rx_hold_left;
    int rx_stall_left;

    always #(CLK_HALF) clk = ~clk;

    function automatic logic [15:0] clamp16(input longint unsigned v);
        return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic logic [15:0] window_stel();
        longint unsigned s;
        s = 0;
        for (int i = 1; i < WINDOW_LEN; i++)
        begin
            s += sh_window[i];
        end
        s += (longint'(sh_window[0]) * (PERIOD_SAMPLES - sh_sample_idx)) / PERIOD_SAMPLES;
        s += sh_minute_sum / PERIOD_SAMPLES;
        return clamp16((s + WINDOW_LEN / 2) / WINDOW_LEN);
    endfunction

    task automatic predict_exposure(input logic [CONC_W-1:0] conc, output exposure_t lv);
        longint unsigned avg;
        longint unsigned t;
        lv = '0;
        sh_minute_sum += conc;
        sh_sample_idx++;
        if (sh_sample_idx >= PERIOD_SAMPLES)
        begin
            avg = (sh_minute_sum + PERIOD_SAMPLES / 2) / PERIOD_SAMPLES;
            for (int i = 0; i + 1 < WINDOW_LEN; i++)
            begin
                sh_window[i] = sh_window[i + 1];
            end
            sh_window[WINDOW_LEN - 1] = clamp16(avg);
            sh_minute_sum = 0;
            sh_sample_idx = 0;
            sh_minutes++;
        end
        if (sh_sample_idx % STEL_EVERY == 0)
        begin
            sh_stel = window_stel();
            lv.stel_fresh = 1'b1;
        end
        if (sh_minutes >= TWA_MINUTES)
        begin
            t = sh_twa_acc * (TWA_WT - 1) + longint'(TWA_SCALE) * sh_stel;
            sh_twa_acc = (t / TWA_WT) & ACC_MASK;
            sh_twa = clamp16(sh_twa_acc / TWA_SCALE);
            sh_minutes = 0;
            lv.twa_fresh = 1'b1;
        end
        lv.stel_level = sh_stel;
        lv.twa_level  = sh_twa;
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatch_count < 40)
        begin
            $display("mismatch on result %0d: %s got %0d, expected %0d",
                     results_seen, what, got, want);
        end
        mismatch_count++;
    endtask

    // Offers one sample and waits for its transfer; the expectation is queued on acceptance.
    task automatic send_sample(input logic [CONC_W-1:0] conc);
        exposure_t lv;
        int gap;
        if (tx_idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            repeat (gap)
            begin
                @(negedge clk);
                sample_ch.valid = 1'b0;
                sample_ch.concentration = CONC_W'($urandom);
            end
        end
        @(negedge clk);
        sample_ch.valid = 1'b1;
        sample_ch.concentration = conc;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        predict_exposure(conc, lv);
        pending_levels.push_back(lv);
        samples_sent++;
        if (lv.stel_fresh)
            stel_refreshes++;
        if (lv.twa_fresh)
            twa_updates++;
    endtask

    task automatic stop_sending();
        @(negedge clk);
        sample_ch.valid = 1'b0;
    endtask

    task automatic test_startup_extremes();
        logic [CONC_W-1:0] vals [20];
        vals = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF,
                 16'h5555, 16'hAAAA, 16'h0001, 16'h8000, 16'h7FFF,
                 16'hFFFE, 16'h00FF, 16'hFF00, 16'h0F0F, 16'hF0F0,
                 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000};
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        foreach (vals[i])
            send_sample(vals[i]);
    endtask

    // Samples come in stretches of one profile, so minute averages swing across the range.
    task automatic send_profiled(input int count);
        conc_profile_t prof;
        int run_left;
        logic [CONC_W-1:0] flat_val;
        logic [CONC_W-1:0] c;
        run_left = 0;
        prof = PROF_FULL;
        flat_val = '0;
        for (int n = 0; n < count; n++)
        begin
            if (run_left == 0)
            begin
                prof = conc_profile_t'($urandom_range(0, 3));
                run_left = $urandom_range(20, 130);
                case ($urandom_range(0, 2))
                    0: flat_val = 16'h0000;
                    1: flat_val = 16'hFFFF;
                    default: flat_val = CONC_W'($urandom);
                endcase
            end
            run_left--;
            case (prof)
                PROF_LOW:  c = CONC_W'($urandom_range(0, 255));
                PROF_HIGH: c = CONC_W'(16'hFFFF - $urandom_range(0, 255));
                PROF_FLAT: c = flat_val;
                default:   c = CONC_W'($urandom_range(0, 65535));
            endcase
            send_sample(c);
        end
    endtask

    task automatic test_random_profiles();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        send_profiled(700);
    endtask

    // The results side holds off long enough that the unit stops taking samples.
    task automatic test_output_backpressure();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b1;
        rx_hold_left = 600;
        for (int n = 0; n < 6; n++)
            send_sample(CONC_W'($urandom));
    endtask

    task automatic test_drain_pause();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        send_profiled(20);
        stop_sending();
        wait (pending_levels.size() == 0);
        send_profiled(20);
    endtask

    task automatic test_steady_stream();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_profiled(380);
        stop_sending();
    endtask

    // Results side: random stall bursts, an optional long hold, or always ready.
    initial
    begin
        result_ch.ready = 1'b0;
        rx_stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold_left > 0)
            begin
                result_ch.ready = 1'b0;
                rx_hold_left--;
            end
            else if (!rx_idle_on)
                result_ch.ready = 1'b1;
            else if (rx_stall_left > 0)
            begin
                result_ch.ready = 1'b0;
                rx_stall_left--;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                result_ch.ready = 1'b0;
                rx_stall_left = $urandom_range(1, 6) - 1;
            end
            else
                result_ch.ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        exposure_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_levels.size() == 0)
                report_mismatch("unexpected result, count", 1, 0);
            else
            begin
                want = pending_levels.pop_front();
                if (result_ch.stel_level !== want.stel_level)
                    report_mismatch("stel_level", result_ch.stel_level, want.stel_level);
                if (result_ch.stel_fresh !== want.stel_fresh)
                    report_mismatch("stel_fresh", result_ch.stel_fresh, want.stel_fresh);
                if (result_ch.twa_level !== want.twa_level)
                    report_mismatch("twa_level", result_ch.twa_level, want.twa_level);
                if (result_ch.twa_fresh !== want.twa_fresh)
                    report_mismatch("twa_fresh", result_ch.twa_fresh, want.twa_fresh);
            end
            results_seen++;
        end
    end

    initial
    begin
        repeat (LIMIT_CYCLES)
            @(posedge clk);
        $display("tb_gas_exposure_stel_twa_unit: FAIL");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        sample_ch.valid = 1'b0;
        sample_ch.concentration = '0;
        sh_minute_sum = 0;
        sh_sample_idx = 0;
        foreach (sh_window[i])
            sh_window[i] = '0;
        sh_minutes = 0;
        sh_stel = '0;
        sh_twa_acc = 0;
        sh_twa = '0;
        mismatch_count = 0;
        samples_sent = 0;
        results_seen = 0;
        stel_refreshes = 0;
        twa_updates = 0;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        rx_hold_left = 0;
        repeat (RESET_CYCLES)
            @(negedge clk);
        rst_n = 1'b1;

        test_startup_extremes();
        test_random_profiles();
        test_output_backpressure();
        test_drain_pause();
        test_steady_stream();

        wait (pending_levels.size() == 0);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        $display("Sent %0d samples and checked %0d results under idle and stall patterns.",
                 samples_sent, results_seen);
        $display("The run saw %0d STEL refreshes and %0d TWA updates.",
                 stel_refreshes, twa_updates);
        if (mismatch_count == 0)
            $display("tb_gas_exposure_stel_twa_unit: PASS");
        else
            $display("tb_gas_exposure_stel_twa_unit: FAIL");
        $finish;
    end

endmodule
